/* sv/capq_pkg.sv */
// capq_pkg: types, constants and the state encoding shared by the
// complex_to_amp_phase_quantizer front, back and top level; no dependencies
`default_nettype none

package capq_pkg;

	localparam int TABLE_SIZE_DEF  = 256;
	localparam int PHASE_STEPS_DEF = 256;
	localparam int CORDIC_STEPS    = 24;
	localparam int XW              = 34;   // cordic datapath width

	localparam logic [30:0] INV_GAIN_Q30 = 31'd652032874;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_DROP,
		KIND_CONVERT
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic [7:0]         idx;
		logic [30:0]        val;
	} item_t;

	typedef struct packed {
		logic [7:0] phase_code;
		logic [7:0] amplitude_code;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VEC,
		ST_CODE,
		ST_ROT_PREP,
		ST_ROT,
		ST_MUL,
		ST_RND,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_NB_LO,
		ST_NB_HI,
		ST_NB_CMP,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

/* sv/complex_to_amp_phase_quantizer.sv */
// a convert beat runs two 24-step passes of the shared cordic (vectoring for the phase code,
// then rotation for the projection), then a binary search of the table and the neighbor compare
// one convert in flight at a time; the back end takes load beats straight from its idle state
// a finished result waits in its own register while the front queue keeps taking beats until full
// reset: arst_n clears queue, sequencer and result valid; the magnitude table is not cleared
`default_nettype none

module complex_to_amp_phase_quantizer #(
	parameter int TABLE_SIZE  = capq_pkg::TABLE_SIZE_DEF,
	parameter int PHASE_STEPS = capq_pkg::PHASE_STEPS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	output logic              full,
	input  wire               cmd,
	input  wire signed [15:0] in_real,
	input  wire signed [15:0] in_imag,
	input  wire [7:0]         table_index,
	input  wire [30:0]        table_value,
	output logic              empty,
	input  wire               pop,
	output logic [7:0]        phase_code,
	output logic [7:0]        amplitude_code
);
	import capq_pkg::*;

	// front to back: queued, classified beats
	logic    q_valid;
	logic    q_pop;
	item_t   q_item;
	result_t res;

	// front: classify load / out-of-range load / convert and queue up to two beats
	capq_front #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.in_real     (in_real),
		.in_imag     (in_imag),
		.table_index (table_index),
		.table_value (table_value),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	// back: table writes, angle and projection via cordic, nearest-entry search
	capq_back #(
		.TABLE_SIZE  (TABLE_SIZE),
		.PHASE_STEPS (PHASE_STEPS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign phase_code     = res.phase_code;
	assign amplitude_code = res.amplitude_code;

endmodule

`default_nettype wire

/* sv/capq_front.sv */
// capq_front: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end; depends on capq_pkg
`default_nettype none

module capq_front #(
	parameter int TABLE_SIZE = capq_pkg::TABLE_SIZE_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  wire                  cmd,
	input  wire signed [15:0]    in_real,
	input  wire signed [15:0]    in_imag,
	input  wire [7:0]            table_index,
	input  wire [30:0]           table_value,
	output logic                 q_valid,
	output capq_pkg::item_t      q_item,
	input  wire                  q_pop
);
	import capq_pkg::*;

	item_t      slot_q [2];
	item_t      item_in;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	// classify: loads past the table end are dropped by the back end
	always_comb begin
		item_in.re  = in_real;
		item_in.im  = in_imag;
		item_in.idx = table_index;
		item_in.val = table_value;
		if (cmd == CMD_CONVERT) begin
			item_in.kind = KIND_CONVERT;
		end else if ({1'b0, table_index} < 9'(TABLE_SIZE)) begin
			item_in.kind = KIND_LOAD;
		end else begin
			item_in.kind = KIND_DROP;
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/capq_back.sv */
// capq_back: magnitude table memory, shared cordic unit, binary search and
// the result register; depends on capq_pkg
`default_nettype none

module capq_back #(
	parameter int TABLE_SIZE  = capq_pkg::TABLE_SIZE_DEF,
	parameter int PHASE_STEPS = capq_pkg::PHASE_STEPS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	input  capq_pkg::item_t      q_item,
	output logic                 q_pop,
	output logic                 empty,
	input  wire                  pop,
	output capq_pkg::result_t    res
);
	import capq_pkg::*;

	localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam logic signed [XW-1:0] QUARTER = XW'(64'sd1073741824);
	localparam logic signed [XW-1:0] HALF    = XW'(64'sd2147483648);

	// direction angle of each phase code
	logic [31:0] phi_tab [256];
	for (genvar g = 0; g < 256; g++) begin : g_phi
		localparam logic [31:0] PHI_G = (g < PHASE_STEPS) ?
			32'((64'(g) << 32) / PHASE_STEPS) : 32'd0;
		assign phi_tab[g] = PHI_G;
	end

	state_t state_q, state_d;

	logic [30:0]             mem_q [TABLE_SIZE];
	logic [30:0]             rdata_q;
	logic                    mem_we;
	logic [AW-1:0]           rd_addr;

	logic signed [15:0]      re_q, im_q;
	logic signed [XW-1:0]    x_q, y_q, z_q;
	logic [4:0]              iter_q;
	logic [7:0]              code_q;
	logic signed [63:0]      prod_q;
	logic signed [17:0]      proj_q;
	logic [CW-1:0]           first_q, cnt_q;
	logic [30:0]             lo_q;
	logic [7:0]              amp_q;
	logic                    res_valid_q;
	result_t                 res_q;
	logic                    res_load;

	logic signed [XW-1:0]    dx, dy, atan_x;
	logic signed [XW-1:0]    re_x, im_x, zneg;
	logic [40:0]             scaled;
	logic [8:0]              code_raw;
	logic [CW-1:0]           step;
	logic signed [XW-1:0]    proj_x, rd_x, lo_x, below, above;
	logic                    rd_less;
	logic                    last_iter;

	assign dx        = y_q >>> iter_q;
	assign dy        = x_q >>> iter_q;
	assign atan_x    = XW'({2'b00, ATAN_TURNS[iter_q]});
	assign re_x      = XW'({{(XW-30){re_q[15]}}, re_q, 14'd0});
	assign im_x      = XW'({{(XW-30){im_q[15]}}, im_q, 14'd0});
	assign zneg      = XW'($signed(32'd0 - phi_tab[code_q]));
	assign scaled    = {9'd0, z_q[31:0]} * 41'(PHASE_STEPS) + 41'h0_8000_0000;
	assign code_raw  = scaled[40:32];
	assign step      = cnt_q >> 1;
	assign proj_x    = XW'(proj_q);
	assign rd_x      = XW'({1'b0, rdata_q});
	assign lo_x      = XW'({1'b0, lo_q});
	assign rd_less   = rd_x < proj_x;
	assign below     = proj_x - lo_x;
	assign above     = rd_x - proj_x;
	assign last_iter = (iter_q == 5'(CORDIC_STEPS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.kind == KIND_CONVERT) begin
					state_d = ST_VEC;
				end
			end
			ST_VEC:      state_d = last_iter ? ST_CODE : ST_VEC;
			ST_CODE:     state_d = ST_ROT_PREP;
			ST_ROT_PREP: state_d = ST_ROT;
			ST_ROT:      state_d = last_iter ? ST_MUL : ST_ROT;
			ST_MUL:      state_d = ST_RND;
			ST_RND:      state_d = ST_SRCH_RD;
			ST_SRCH_RD:  state_d = ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				if (rd_less) begin
					state_d = (cnt_q - step - CW'(1) == '0) ? ST_NB_LO : ST_SRCH_RD;
				end else begin
					state_d = (step == '0) ? ST_NB_LO : ST_SRCH_RD;
				end
			end
			ST_NB_LO: begin
				if (first_q == '0 || first_q >= CW'(TABLE_SIZE)) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_NB_HI;
				end
			end
			ST_NB_HI:    state_d = ST_NB_CMP;
			ST_NB_CMP:   state_d = ST_OUT;
			ST_OUT:      state_d = (!res_valid_q || pop) ? ST_IDLE : ST_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		rd_addr  = '0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop  = q_valid;
				mem_we = q_valid && (q_item.kind == KIND_LOAD);
			end
			ST_SRCH_RD: rd_addr = AW'(first_q + step);
			ST_NB_LO:   rd_addr = AW'(first_q - CW'(1));
			ST_NB_HI:   rd_addr = AW'(first_q);
			ST_OUT:     res_load = !res_valid_q || pop;
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[AW'(q_item.idx)] <= q_item.val;
		end
		rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				re_q   <= q_item.re;
				im_q   <= q_item.im;
				iter_q <= '0;
				if (q_item.re < 0) begin
					x_q <= -XW'({{(XW-30){q_item.re[15]}}, q_item.re, 14'd0});
					y_q <= -XW'({{(XW-30){q_item.im[15]}}, q_item.im, 14'd0});
					z_q <= XW'(64'sd2147483648);
				end else begin
					x_q <= XW'({{(XW-30){q_item.re[15]}}, q_item.re, 14'd0});
					y_q <= XW'({{(XW-30){q_item.im[15]}}, q_item.im, 14'd0});
					z_q <= '0;
				end
			end
			// vectoring steers by y
			ST_VEC: begin
				iter_q <= iter_q + 5'd1;
				if (y_q < 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_x;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_x;
				end
			end
			// rotation steers by the residual angle
			ST_ROT: begin
				iter_q <= iter_q + 5'd1;
				if (z_q < 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_x;
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_x;
				end
			end
			ST_CODE: begin
				if ((re_q == 0 && im_q == 0) || code_raw >= 9'(PHASE_STEPS)) begin
					code_q <= '0;
				end else begin
					code_q <= code_raw[7:0];
				end
			end
			ST_ROT_PREP: begin
				iter_q <= '0;
				if (zneg > QUARTER) begin
					x_q <= -re_x;
					y_q <= -im_x;
					z_q <= zneg - HALF;
				end else if (zneg < -QUARTER) begin
					x_q <= -re_x;
					y_q <= -im_x;
					z_q <= zneg + HALF;
				end else begin
					x_q <= re_x;
					y_q <= im_x;
					z_q <= zneg;
				end
			end
			ST_MUL: prod_q <= 64'($signed(x_q[31:0]) * $signed({1'b0, INV_GAIN_Q30}));
			ST_RND: begin
				proj_q  <= 18'((prod_q + 64'sd8796093022208) >>> 44);
				first_q <= '0;
				cnt_q   <= CW'(TABLE_SIZE);
			end
			ST_SRCH_CMP: begin
				if (rd_less) begin
					first_q <= first_q + step + CW'(1);
					cnt_q   <= cnt_q - step - CW'(1);
				end else begin
					cnt_q   <= step;
				end
			end
			ST_NB_LO: begin
				if (first_q == '0) begin
					amp_q <= '0;
				end else begin
					amp_q <= 8'(TABLE_SIZE - 1);
				end
			end
			ST_NB_HI: lo_q <= rdata_q;
			ST_NB_CMP: begin
				amp_q <= (below <= above) ? 8'(first_q - CW'(1)) : 8'(first_q);
			end
			default: begin
				iter_q <= iter_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.phase_code     <= code_q;
			res_q.amplitude_code <= amp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	assign empty = !res_valid_q;
	assign res   = res_q;

endmodule

`default_nettype wire

/* sv/capq_checker.sv */
// capq_checker: port-level checks for complex_to_amp_phase_quantizer and the
// bind that attaches them; depends on the top level only
`default_nettype none

module capq_checker #(
	parameter int TABLE_SIZE  = 256,
	parameter int PHASE_STEPS = 256
) (
	input wire       clk,
	input wire       arst_n,
	input wire       empty,
	input wire       pop,
	input wire [7:0] phase_code,
	input wire [7:0] amplitude_code
);

	// no result beat is shown while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(phase_code) && $stable(amplitude_code))
		else $error("waiting result changed");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> 9'(phase_code) < 9'(PHASE_STEPS))
		else $error("phase code out of range");

	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> 9'(amplitude_code) < 9'(TABLE_SIZE))
		else $error("amplitude code out of range");

endmodule

bind complex_to_amp_phase_quantizer capq_checker #(
	.TABLE_SIZE  (TABLE_SIZE),
	.PHASE_STEPS (PHASE_STEPS)
) u_capq_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.phase_code     (phase_code),
	.amplitude_code (amplitude_code)
);

`default_nettype wire
